@@ rtl/dtps_pkg.sv @@
// ---------------------------------------------------------------------------
// dtps_pkg
// Shared types and constants of the depth-tested point splat block.
// ---------------------------------------------------------------------------
package dtps_pkg;

  localparam int DEF_GRID_SIZE     = 256;
  localparam int DEF_KERNEL_RADIUS = 10;

  // exp(-1/18) in Q0.32: one step of the Gaussian kernel, tau 3
  localparam logic [63:0] EXP_STEP = 64'd4062864944;

  typedef enum logic [1:0] {
    OP_PLOT  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_ADDR,
    S_EXEC,
    S_WALK,
    S_WTAIL,
    S_CLR
  } state_t;

  typedef struct packed {
    logic        plotted;
    logic        occupied;
    logic [15:0] stored_tag;
    logic [15:0] stored_attribute;
    logic [15:0] stored_depth;
    logic [31:0] heat_value;
  } res_t;

endpackage

@@ rtl/dtps_if.sv @@
// ---------------------------------------------------------------------------
// dtps_if
// Valid/ready channels of the point splat block: input word and result word.
// ---------------------------------------------------------------------------
interface dtps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] x_coord;
  logic [15:0] y_coord;
  logic [15:0] depth_z;
  logic [15:0] tag;
  logic [15:0] attribute;
  logic [7:0]  cell_col;
  logic [7:0]  cell_row;

  modport source (output valid, op, x_coord, y_coord, depth_z, tag, attribute,
                  cell_col, cell_row, input ready);
  modport sink   (input valid, op, x_coord, y_coord, depth_z, tag, attribute,
                  cell_col, cell_row, output ready);
endinterface

interface dtps_out_if;
  logic        valid;
  logic        ready;
  logic        plotted;
  logic        occupied;
  logic [15:0] stored_tag;
  logic [15:0] stored_attribute;
  logic [15:0] stored_depth;
  logic [31:0] heat_value;

  modport source (output valid, plotted, occupied, stored_tag, stored_attribute,
                  stored_depth, heat_value, input ready);
  modport sink   (input valid, plotted, occupied, stored_tag, stored_attribute,
                  stored_depth, heat_value, output ready);
endinterface

@@ rtl/depth_tested_point_splat.sv @@
// ---------------------------------------------------------------------------
// depth_tested_point_splat
// Z-buffer point rasterizer with Gaussian heat splat over a square grid.
// ---------------------------------------------------------------------------
// Usage:
//   in_if  : one word per operation (plot, read, clear); accepted on
//            valid && ready. One word is in work at a time.
//   out_if : one result word per input word, held in an output register
//            until taken; a stalled receiver never loses a word.
//   cfg_we / cfg_data : mode register (0 nearest depth, 1 heat density), to be
//            written only while the block is idle; the block does not enforce it.
// Steps per word, from accept to result register:
//   plot (depth mode), read, dropped plot : map, address, memory read
//   plot (density mode) : map, address, then one kernel cell per cycle
//            through the read-modify-write of the occupancy/heat memory
//   clear : map, then one memory entry per cycle
// Reset: a clearing pass over all GRID_SIZE^2 entries (65536 by default)
// empties occupancy and zeroes heat; in_if.ready stays low until it ends.
// A new word is taken once the block is idle and the output register is
// free or being drained in the same cycle.
// ---------------------------------------------------------------------------
module depth_tested_point_splat
  import dtps_pkg::*;
#(
  parameter int GRID_SIZE     = DEF_GRID_SIZE,
  parameter int KERNEL_RADIUS = DEF_KERNEL_RADIUS
) (
  input  logic        clk,
  input  logic        rst_n,
  dtps_in_if.sink     in_if,
  dtps_out_if.source  out_if,
  input  logic        cfg_we,
  input  logic        cfg_data
);

  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(GRID_SIZE);
  localparam int WLEN  = 2 * KERNEL_RADIUS * KERNEL_RADIUS + 1;
  localparam int WIW   = $clog2(WLEN);
  localparam logic signed [5:0] RPOS = 6'(KERNEL_RADIUS);
  localparam logic signed [5:0] RNEG = -6'(KERNEL_RADIUS);
  localparam logic [AW-1:0] NA     = AW'(GRID_SIZE);
  localparam logic [AW-1:0] RA     = AW'(KERNEL_RADIUS);
  localparam logic [AW-1:0] ROWJMP = AW'(GRID_SIZE - 2 * KERNEL_RADIUS);
  localparam logic [AW-1:0] LASTA  = AW'(CELLS - 1);

  typedef logic [16:0] wtab_t [WLEN];

  // Gaussian weights in Q1.15, built at elaboration in integer steps
  function automatic wtab_t build_wtab();
    logic [63:0] v;
    wtab_t       tb;
    int          k;
    v = 64'h1_0000_0000;
    for (k = 0; k < WLEN; k++) begin
      tb[k] = 17'((v + 64'h1_0000) >> 17);
      v     = (v * EXP_STEP + 64'h8000_0000) >> 32;
    end
    return tb;
  endfunction

  localparam wtab_t WTAB = build_wtab();

  // captured input word
  op_t         op_r;
  logic [15:0] x_r, y_r, z_r, tag_r, attr_r;
  logic [7:0]  ccol_r, crow_r;
  logic        mode_r;

  // mapped cell
  logic [CW-1:0] col_r, row_r;
  logic          inb_r;
  logic [CW-1:0] xc_idx, yc_idx;
  logic          xc_ok, yc_ok;

  state_t state_r, state_nxt;

  // kernel walk
  logic [AW-1:0]      walk_addr_r, walk_addr_nxt;
  logic signed [5:0]  dx_r, dx_nxt, dy_r, dy_nxt;
  logic               wp_valid_r;
  logic [AW-1:0]      wp_addr_r;
  logic [16:0]        wp_w_r;
  logic               wp_ctr_r;
  logic signed [11:0] dxx, dyy;
  logic [WIW-1:0]     widx;

  // clearing pass
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          reply_r, reply_nxt;

  // memories: A holds {occupied, heat}, B holds {tag, attribute, depth}
  logic          a_we, b_we;
  logic [AW-1:0] a_waddr, a_raddr, b_waddr;
  logic [32:0]   a_wdata, a_rdata;
  logic [47:0]   b_wdata, b_rdata;
  logic [AW-1:0] cell_addr, walk_start;
  logic [32:0]   heat_sum;

  // result
  logic res_load;
  res_t res, out_r;
  logic out_valid_r;
  logic accept, win;

  dtps_coord #(.GRID_SIZE(GRID_SIZE), .KERNEL_RADIUS(KERNEL_RADIUS), .CW(CW))
    u_xmap (.coord(x_r), .idx(xc_idx), .ok(xc_ok));
  dtps_coord #(.GRID_SIZE(GRID_SIZE), .KERNEL_RADIUS(KERNEL_RADIUS), .CW(CW))
    u_ymap (.coord(y_r), .idx(yc_idx), .ok(yc_ok));

  dtps_ram #(.WIDTH(33), .DEPTH(CELLS), .AW(AW)) u_heat_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata));
  dtps_ram #(.WIDTH(48), .DEPTH(CELLS), .AW(AW)) u_data_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(a_raddr), .rdata(b_rdata));

  assign in_if.ready = (state_r == S_IDLE) && (!out_valid_r || out_if.ready);
  assign accept      = in_if.valid && in_if.ready;

  assign cell_addr  = AW'(row_r) * NA + AW'(col_r);
  assign walk_start = (AW'(row_r) - RA) * NA + (AW'(col_r) - RA);
  assign dxx        = 12'(dx_r) * 12'(dx_r);
  assign dyy        = 12'(dy_r) * 12'(dy_r);
  assign widx       = WIW'(dxx + dyy);
  assign heat_sum   = {1'b0, a_rdata[31:0]} + {16'd0, wp_w_r};

  // nearer depth or empty cell wins in depth mode
  assign win = !a_rdata[32] || ($signed(b_rdata[15:0]) > $signed(z_r));

  always_comb begin
    state_nxt     = state_r;
    walk_addr_nxt = walk_addr_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    clr_cnt_nxt   = clr_cnt_r;
    reply_nxt     = reply_r;
    a_raddr       = cell_addr;
    a_we          = 1'b0;
    a_waddr       = wp_addr_r;
    a_wdata       = {wp_ctr_r | a_rdata[32],
                     heat_sum[32] ? 32'hFFFF_FFFF : heat_sum[31:0]};
    b_we          = 1'b0;
    b_waddr       = cell_addr;
    b_wdata       = {tag_r, attr_r, z_r};
    res_load      = 1'b0;
    res           = '0;

    // kernel writeback follows the read in the next cycle
    if (wp_valid_r) begin
      a_we = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        if (op_r == OP_CLEAR) begin
          clr_cnt_nxt = '0;
          reply_nxt   = 1'b1;
          state_nxt   = S_CLR;
        end else begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        if (op_r == OP_PLOT && inb_r && mode_r) begin
          walk_addr_nxt = walk_start;
          dx_nxt        = RNEG;
          dy_nxt        = RNEG;
          state_nxt     = S_WALK;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_load  = 1'b1;
        state_nxt = S_IDLE;
        if (inb_r && op_r == OP_PLOT) begin
          if (win) begin
            a_we        = 1'b1;
            a_waddr     = cell_addr;
            a_wdata     = {1'b1, a_rdata[31:0]};
            b_we        = 1'b1;
            res.plotted = 1'b1;
          end
        end else if (inb_r && op_r == OP_READ) begin
          res.occupied   = a_rdata[32];
          res.heat_value = a_rdata[31:0];
          if (a_rdata[32]) begin
            res.stored_tag       = b_rdata[47:32];
            res.stored_attribute = b_rdata[31:16];
            res.stored_depth     = b_rdata[15:0];
          end
        end
      end
      S_WALK: begin
        a_raddr = walk_addr_r;
        if (dx_r == RPOS) begin
          dx_nxt        = RNEG;
          dy_nxt        = dy_r + 6'sd1;
          walk_addr_nxt = walk_addr_r + ROWJMP;
          if (dy_r == RPOS) begin
            state_nxt = S_WTAIL;
          end
        end else begin
          dx_nxt        = dx_r + 6'sd1;
          walk_addr_nxt = walk_addr_r + AW'(1);
        end
      end
      S_WTAIL: begin
        res_load    = 1'b1;
        res.plotted = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_CLR: begin
        a_we        = 1'b1;
        a_waddr     = clr_cnt_r;
        a_wdata     = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LASTA) begin
          res_load  = reply_r;
          reply_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      reply_r     <= 1'b0;
      wp_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      reply_r    <= reply_nxt;
      wp_valid_r <= (state_r == S_WALK);
      if (cfg_we) begin
        mode_r <= cfg_data;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_if.op);
      x_r    <= in_if.x_coord;
      y_r    <= in_if.y_coord;
      z_r    <= in_if.depth_z;
      tag_r  <= in_if.tag;
      attr_r <= in_if.attribute;
      ccol_r <= in_if.cell_col;
      crow_r <= in_if.cell_row;
    end
    if (state_r == S_MAP) begin
      if (op_r == OP_PLOT) begin
        col_r <= xc_idx;
        row_r <= yc_idx;
        inb_r <= xc_ok && yc_ok;
      end else begin
        col_r <= CW'(ccol_r);
        row_r <= CW'(crow_r);
        inb_r <= (op_r == OP_READ) && (32'(ccol_r) < 32'(GRID_SIZE))
                 && (32'(crow_r) < 32'(GRID_SIZE));
      end
    end
    walk_addr_r <= walk_addr_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    wp_addr_r   <= walk_addr_r;
    wp_w_r      <= WTAB[widx];
    wp_ctr_r    <= (dx_r == 6'sd0) && (dy_r == 6'sd0);
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.plotted          = out_r.plotted;
  assign out_if.occupied         = out_r.occupied;
  assign out_if.stored_tag       = out_r.stored_tag;
  assign out_if.stored_attribute = out_r.stored_attribute;
  assign out_if.stored_depth     = out_r.stored_depth;
  assign out_if.heat_value       = out_r.heat_value;

endmodule

@@ rtl/dtps_ram.sv @@
// ---------------------------------------------------------------------------
// dtps_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module dtps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/dtps_coord.sv @@
// ---------------------------------------------------------------------------
// dtps_coord
// Map one Q2.14 coordinate to a grid index and test the kernel fits.
// ---------------------------------------------------------------------------
module dtps_coord #(
  parameter int GRID_SIZE     = 256,
  parameter int KERNEL_RADIUS = 10,
  parameter int CW            = 8
) (
  input  logic [15:0]   coord,
  output logic [CW-1:0] idx,
  output logic          ok
);

  localparam logic signed [27:0] NS   = 28'(GRID_SIZE);
  localparam logic signed [27:0] MID  = 28'((GRID_SIZE + 1) / 2 - 1);
  localparam logic signed [27:0] LO   = 28'(KERNEL_RADIUS);
  localparam logic signed [27:0] HI   = 28'(GRID_SIZE - 1 - KERNEL_RADIUS);
  localparam logic signed [27:0] HALF = 28'sd16384;

  logic signed [27:0] cx;
  logic signed [27:0] t;
  logic signed [27:0] pos;

  always_comb begin
    cx  = 28'($signed(coord));
    t   = cx * NS + HALF;
    pos = (t >>> 15) + MID;        // floor of round-half-up
    ok  = (pos >= LO) && (pos <= HI);
    idx = pos[CW-1:0];
  end

endmodule

@@ rtl/dtps_checker.sv @@
// ---------------------------------------------------------------------------
// dtps_checker
// Port-level checks of the point splat block, bound to the top level.
// ---------------------------------------------------------------------------
module dtps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_plotted,
  input logic        out_occupied,
  input logic [15:0] out_tag,
  input logic [15:0] out_attr,
  input logic [15:0] out_depth
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // one word in work at a time
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  // clearing pass after reset blocks input
  a_reset_clear: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_ready)
    else $error("input taken during reset clearing pass");

  // a plot result never reports a cell, an empty cell reports no point
  a_res_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_occupied |->
      out_tag == 16'd0 && out_attr == 16'd0 && out_depth == 16'd0)
    else $error("empty cell shows stored point");

  a_plot_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_plotted |-> !out_occupied)
    else $error("plot result carries read fields");

endmodule

bind depth_tested_point_splat dtps_checker u_dtps_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_plotted (out_if.plotted),
  .out_occupied(out_if.occupied),
  .out_tag     (out_if.stored_tag),
  .out_attr    (out_if.stored_attribute),
  .out_depth   (out_if.stored_depth)
);
